// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the execute unit modules
// Clocked property checks that are switched off while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that cond is never true at a rising clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

// File: rtl/core/mie_pkg.sv
// ----------------------------------------------------------------------------
// MIPS I-format execute unit package
// Opcodes, status codes, stream widths and the request types passed between
// the execute pipeline and its register file and data memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mie_pkg;

    // Stream widths
    localparam int unsigned INSTR_W = 32;
    localparam int unsigned RES_W   = 144;

    // Supported opcodes
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_ADDIU = 6'h09;
    localparam logic [5:0] OP_SLTI  = 6'h0a;
    localparam logic [5:0] OP_ANDI  = 6'h0c;
    localparam logic [5:0] OP_ORI   = 6'h0d;
    localparam logic [5:0] OP_LUI   = 6'h0f;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SB    = 6'h28;
    localparam logic [5:0] OP_SH    = 6'h29;
    localparam logic [5:0] OP_SW    = 6'h2b;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNKNOWN  = 2'd1;
    localparam logic [1:0] ST_MISALIGN = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // Register file write request
    typedef struct packed {
        logic        en;
        logic [4:0]  addr;
        logic [31:0] data;
    } rf_wr_t;

    // Data memory access control
    typedef struct packed {
        logic       rd;
        logic       wr;
        logic [3:0] mask;
    } dm_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/mie_regfile.sv
// ----------------------------------------------------------------------------
// MIPS I-format register file
// 32 x 32 synchronous RAM with two registered read ports and one write port.
// Per-entry valid bits make every entry read as zero after reset; entry zero
// is never written and so always reads zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mie_regfile (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           rd_en,
    input  wire logic [4:0]     rs_addr,
    input  wire logic [4:0]     rt_addr,
    input  wire mie_pkg::rf_wr_t wr_req,
    output logic [31:0]         rs_data,
    output logic [31:0]         rt_data
);

    logic [31:0] mem [0:31];
    logic [31:0] vld_reg;
    logic [31:0] rs_raw_reg;
    logic [31:0] rt_raw_reg;
    logic        rs_vld_reg;
    logic        rt_vld_reg;

    // Mark entries written since reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_req.en) begin
            vld_reg[wr_req.addr] <= 1'b1;
        end
    end

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_req.en) begin
            mem[wr_req.addr] <= wr_req.data;
        end
    end

    // Registered read ports, old data on a same-cycle write
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rs_raw_reg <= mem[rs_addr];
            rt_raw_reg <= mem[rt_addr];
            rs_vld_reg <= vld_reg[rs_addr];
            rt_vld_reg <= vld_reg[rt_addr];
        end
    end

    assign rs_data = rs_vld_reg ? rs_raw_reg : '0;
    assign rt_data = rt_vld_reg ? rt_raw_reg : '0;

    `ASSERT_CLK(a_rf_no_r0_write, aclk, aresetn, wr_req.en |-> (wr_req.addr != 5'd0), "register zero written")

endmodule

`default_nettype wire

// File: rtl/core/mie_data_mem.sv
// ----------------------------------------------------------------------------
// MIPS I-format data memory
// Word-wide synchronous RAM with byte-lane writes and a registered read.
// After reset a clearing pass writes zero to every word, one per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mie_data_mem #(
    parameter int MEM_WORDS = 1024,
    localparam int AW = $clog2(MEM_WORDS)
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire mie_pkg::dm_ctrl_t ctrl,
    input  wire logic [AW-1:0]  idx,
    input  wire logic [31:0]    wdata,
    output logic [31:0]         rdata,
    output logic                clr_busy
);

    logic [31:0]   mem [0:MEM_WORDS-1];
    logic [31:0]   rdata_reg;
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    // Clearing pass sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            if (clr_addr_reg == AW'(MEM_WORDS - 1)) begin
                clr_busy_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // Write port: zero fill during the clearing pass, byte lanes otherwise
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (ctrl.wr) begin
            for (int i = 0; i < 4; i++) begin
                if (ctrl.mask[i]) begin
                    mem[idx][8*i +: 8] <= wdata[8*i +: 8];
                end
            end
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        if (ctrl.rd) begin
            rdata_reg <= mem[idx];
        end
    end

    assign rdata    = rdata_reg;
    assign clr_busy = clr_busy_reg;

    `ASSERT_NEVER(a_dm_idle_while_clearing, aclk, aresetn, clr_busy_reg && (ctrl.rd || ctrl.wr), "data memory accessed during clearing pass")

endmodule

`default_nettype wire

// File: rtl/core/mips_itype_execute_unit.sv
// ----------------------------------------------------------------------------
// MIPS I-format execute unit
// Stages: execute, three word-index stages, memory read, output register.
// Throughput: one instruction per cycle unless m_tready back-pressure stalls;
//   an instruction that reads a register loaded by a lw still in the
//   word-index stages waits until that lw reaches the memory read stage.
// Reset: PC and register file read zero at once; the data memory clearing
//   pass then holds s_tready low until every word has been cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mips_itype_execute_unit #(
    parameter int MEM_WORDS = 1024
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // Input stream
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // [31:0] instr_word
    input  wire logic [mie_pkg::INSTR_W-1:0] s_tdata,
    // Result stream
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // [31:0] next_pc, [32] reg_write, [37:33] reg_index, [69:38] reg_value,
    // [70] mem_write, [102:71] mem_address, [106:103] mem_byte_mask,
    // [138:107] mem_data, [139] branch_taken, [141:140] status, [143:142] zero
    output logic [mie_pkg::RES_W-1:0]        m_tdata
);

    localparam int AW     = $clog2(MEM_WORDS);
    localparam int XBITS  = 30;
    localparam int RECIP  = (2 ** XBITS) / MEM_WORDS;
    localparam int RBITS  = $clog2(RECIP + 1);
    localparam int PBITS  = XBITS + RBITS;
    localparam int MBITS  = $clog2(MEM_WORDS + 1);
    localparam int RRBITS = MBITS + 1;

    typedef struct packed {
        logic [31:0] next_pc;
        logic [4:0]  rt;
        logic        reg_write;
        logic [31:0] reg_value;
        logic        is_load;
        logic        mem_write;
        logic [31:0] mem_address;
        logic [3:0]  mem_byte_mask;
        logic [31:0] mem_data;
        logic        branch_taken;
        logic [1:0]  status;
    } stage_t;

    // Handshake and stage control
    logic        accept;
    logic        out_free;
    logic [3:0]  p_go;
    logic [3:0]  p_free;
    logic        e_go;
    logic        e_free;
    logic        hazard;
    logic        clr_busy;

    // Execute stage
    logic        e_valid_reg;
    logic        e_first_reg;
    logic [31:0] e_instr_reg;
    logic [31:0] e_a_reg;
    logic [31:0] e_b_reg;
    mie_pkg::rf_wr_t ent_reg;
    logic [31:0] pc_reg;

    logic [5:0]  op;
    logic [4:0]  rs_idx;
    logic [4:0]  rt_idx;
    logic [15:0] imm;
    logic [31:0] simm;
    logic [31:0] base_a;
    logic [31:0] base_b;
    logic [31:0] a_fwd;
    logic [31:0] b_fwd;
    logic [31:0] sum;
    logic [31:0] pc4;
    logic        ovf;
    stage_t      ex;

    // Address stages, memory read stage and output register
    logic [3:0]       p_valid_reg;
    stage_t           p_reg [4];
    logic [XBITS-1:0] p0_x_reg;
    logic [XBITS-1:0] p1_x_reg;
    logic [RBITS-1:0] p1_q_reg;
    logic [RRBITS-1:0] p2_r_reg;
    logic [PBITS-1:0] prod;
    logic [XBITS-1:0] qm;
    logic [XBITS-1:0] rr;
    logic [AW-1:0]    word_idx;
    logic             m_valid_reg;
    stage_t           m_reg;
    stage_t           m_next;

    logic [31:0]        l_val;
    logic [31:0]        rf_rs_data;
    logic [31:0]        rf_rt_data;
    logic [31:0]        dm_rdata;
    mie_pkg::rf_wr_t    rf_wr;
    mie_pkg::dm_ctrl_t  dm_ctrl;

    // Advance conditions, output side first
    always_comb begin
        out_free  = !m_valid_reg || m_tready;
        p_go[3]   = p_valid_reg[3] && out_free;
        p_free[3] = !p_valid_reg[3] || out_free;
        for (int i = 2; i >= 0; i--) begin
            p_go[i]   = p_valid_reg[i] && p_free[i+1];
            p_free[i] = !p_valid_reg[i] || p_free[i+1];
        end
        e_go   = e_valid_reg && p_free[0] && !hazard;
        e_free = !e_valid_reg || e_go;
    end

    assign s_tready = e_free && !clr_busy;
    assign accept   = s_tvalid && s_tready;

    // Register file
    assign l_val = p_reg[3].is_load ? dm_rdata : p_reg[3].reg_value;

    always_comb begin
        rf_wr.en   = p_go[3] && p_reg[3].reg_write;
        rf_wr.addr = p_reg[3].rt;
        rf_wr.data = l_val;
    end

    mie_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rs_addr (s_tdata[25:21]),
        .rt_addr (s_tdata[20:16]),
        .wr_req  (rf_wr),
        .rs_data (rf_rs_data),
        .rt_data (rf_rt_data)
    );

    // Decode fields of the instruction in execute
    assign op     = e_instr_reg[31:26];
    assign rs_idx = e_instr_reg[25:21];
    assign rt_idx = e_instr_reg[20:16];
    assign imm    = e_instr_reg[15:0];
    assign simm   = {{16{imm[15]}}, imm};

    // Operand base: fresh RAM read patched by the write of the entry cycle,
    // or the operand kept from the previous stalled cycle
    always_comb begin
        if (e_first_reg) begin
            base_a = (ent_reg.en && ent_reg.addr == rs_idx) ? ent_reg.data : rf_rs_data;
            base_b = (ent_reg.en && ent_reg.addr == rt_idx) ? ent_reg.data : rf_rt_data;
        end else begin
            base_a = e_a_reg;
            base_b = e_b_reg;
        end
    end

    // Forward pending writes, youngest last; stall on a load not yet read
    always_comb begin
        a_fwd  = base_a;
        b_fwd  = base_b;
        hazard = 1'b0;
        for (int i = 3; i >= 0; i--) begin
            if (p_valid_reg[i] && p_reg[i].reg_write) begin
                if (p_reg[i].rt == rs_idx) begin
                    a_fwd = (i == 3) ? l_val : p_reg[i].reg_value;
                end
                if (p_reg[i].rt == rt_idx) begin
                    b_fwd = (i == 3) ? l_val : p_reg[i].reg_value;
                end
                if (i != 3 && p_reg[i].is_load &&
                    (p_reg[i].rt == rs_idx || p_reg[i].rt == rt_idx)) begin
                    hazard = 1'b1;
                end
            end
        end
    end

    // Execute
    assign sum = a_fwd + simm;
    assign ovf = (a_fwd[31] == simm[31]) && (sum[31] != a_fwd[31]);
    assign pc4 = pc_reg + 32'd4;

    always_comb begin
        ex = '0;
        ex.next_pc = pc4;
        ex.status  = mie_pkg::ST_OK;
        unique case (op)
            mie_pkg::OP_ADDI: begin
                if (ovf) begin
                    ex.status = mie_pkg::ST_OVERFLOW;
                end else begin
                    ex.reg_write = 1'b1;
                    ex.reg_value = sum;
                end
            end
            mie_pkg::OP_ADDIU: begin
                ex.reg_write = 1'b1;
                ex.reg_value = sum;
            end
            mie_pkg::OP_ANDI: begin
                ex.reg_write = 1'b1;
                ex.reg_value = a_fwd & {16'd0, imm};
            end
            mie_pkg::OP_ORI: begin
                ex.reg_write = 1'b1;
                ex.reg_value = a_fwd | {16'd0, imm};
            end
            mie_pkg::OP_SLTI: begin
                ex.reg_write = 1'b1;
                ex.reg_value = {31'd0, ($signed(a_fwd) < $signed(simm))};
            end
            mie_pkg::OP_LUI: begin
                ex.reg_write = 1'b1;
                ex.reg_value = {imm, 16'd0};
            end
            mie_pkg::OP_BEQ, mie_pkg::OP_BNE: begin
                ex.branch_taken = (op == mie_pkg::OP_BEQ) ? (a_fwd == b_fwd)
                                                          : (a_fwd != b_fwd);
                if (ex.branch_taken) begin
                    ex.next_pc = pc4 + {simm[29:0], 2'b00};
                end
            end
            mie_pkg::OP_LW: begin
                ex.mem_address = sum;
                if (sum[1:0] != 2'd0) begin
                    ex.status = mie_pkg::ST_MISALIGN;
                end else begin
                    ex.reg_write = 1'b1;
                    ex.is_load   = 1'b1;
                end
            end
            mie_pkg::OP_SW: begin
                ex.mem_address = sum;
                if (sum[1:0] != 2'd0) begin
                    ex.status = mie_pkg::ST_MISALIGN;
                end else begin
                    ex.mem_write     = 1'b1;
                    ex.mem_byte_mask = 4'hf;
                    ex.mem_data      = b_fwd;
                end
            end
            mie_pkg::OP_SH: begin
                ex.mem_address = sum;
                if (sum[0]) begin
                    ex.status = mie_pkg::ST_MISALIGN;
                end else begin
                    ex.mem_write     = 1'b1;
                    ex.mem_byte_mask = sum[1] ? 4'b1100 : 4'b0011;
                    ex.mem_data      = sum[1] ? {b_fwd[15:0], 16'd0} : {16'd0, b_fwd[15:0]};
                end
            end
            mie_pkg::OP_SB: begin
                ex.mem_address   = sum;
                ex.mem_write     = 1'b1;
                ex.mem_byte_mask = 4'b0001 << sum[1:0];
                ex.mem_data      = {24'd0, b_fwd[7:0]} << {sum[1:0], 3'b000};
            end
            default: begin
                ex.status = mie_pkg::ST_UNKNOWN;
            end
        endcase
        // Drop writes to register zero
        if (rt_idx == 5'd0) begin
            ex.reg_write = 1'b0;
            ex.reg_value = '0;
            ex.is_load   = 1'b0;
        end
        ex.rt = ex.reg_write ? rt_idx : 5'd0;
    end

    // Execute stage control and program counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
            e_first_reg <= 1'b0;
            pc_reg      <= '0;
        end else begin
            if (accept) begin
                e_valid_reg <= 1'b1;
                e_first_reg <= 1'b1;
            end else begin
                e_first_reg <= 1'b0;
                if (e_go) begin
                    e_valid_reg <= 1'b0;
                end
            end
            if (e_go) begin
                pc_reg <= ex.next_pc;
            end
        end
    end

    // Execute stage payload; keep forwarded operands while waiting
    always_ff @(posedge aclk) begin
        e_a_reg <= a_fwd;
        e_b_reg <= b_fwd;
        if (accept) begin
            e_instr_reg <= s_tdata;
            ent_reg     <= rf_wr;
        end
    end

    // Stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            p_valid_reg[0] <= e_go || (p_valid_reg[0] && !p_go[0]);
            for (int i = 1; i < 4; i++) begin
                p_valid_reg[i] <= p_go[i-1] || (p_valid_reg[i] && !p_go[i]);
            end
            m_valid_reg <= p_go[3] || (m_valid_reg && !m_tready);
        end
    end

    // Word index: multiply by the reciprocal, take back the quotient,
    // then one correcting subtract
    assign prod = PBITS'(p0_x_reg) * PBITS'(RECIP);
    assign qm   = XBITS'(p1_q_reg) * XBITS'(MEM_WORDS);
    assign rr   = p1_x_reg - qm;

    always_comb begin
        if (p2_r_reg >= RRBITS'(MEM_WORDS)) begin
            word_idx = AW'(p2_r_reg - RRBITS'(MEM_WORDS));
        end else begin
            word_idx = AW'(p2_r_reg);
        end
    end

    // Output payload with the loaded word merged in
    always_comb begin
        m_next           = p_reg[3];
        m_next.reg_value = l_val;
    end

    // Advance stage payloads
    always_ff @(posedge aclk) begin
        if (e_go) begin
            p_reg[0] <= ex;
            p0_x_reg <= ex.mem_address[31:2];
        end
        if (p_go[0]) begin
            p_reg[1] <= p_reg[0];
            p1_x_reg <= p0_x_reg;
            p1_q_reg <= prod[PBITS-1:XBITS];
        end
        if (p_go[1]) begin
            p_reg[2] <= p_reg[1];
            p2_r_reg <= rr[RRBITS-1:0];
        end
        if (p_go[2]) begin
            p_reg[3] <= p_reg[2];
        end
        if (p_go[3]) begin
            m_reg <= m_next;
        end
    end

    // Data memory access from the last index stage
    always_comb begin
        dm_ctrl.rd   = p_go[2] && p_reg[2].is_load;
        dm_ctrl.wr   = p_go[2] && p_reg[2].mem_write;
        dm_ctrl.mask = p_reg[2].mem_byte_mask;
    end

    mie_data_mem #(
        .MEM_WORDS (MEM_WORDS)
    ) u_data_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (dm_ctrl),
        .idx      (word_idx),
        .wdata    (p_reg[2].mem_data),
        .rdata    (dm_rdata),
        .clr_busy (clr_busy)
    );

    // Result stream
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_reg.status, m_reg.branch_taken, m_reg.mem_data,
                       m_reg.mem_byte_mask, m_reg.mem_address, m_reg.mem_write,
                       m_reg.reg_value, m_reg.rt, m_reg.reg_write, m_reg.next_pc};

    `ASSERT_NEVER(a_no_accept_while_clearing, aclk, aresetn, clr_busy && s_tready, "instruction accepted during clearing pass")
    `ASSERT_CLK(a_fault_has_no_write, aclk, aresetn, (m_tvalid && (m_reg.status != mie_pkg::ST_OK)) |-> (!m_reg.reg_write && !m_reg.mem_write), "faulting instruction reports a write")
    `ASSERT_CLK(a_branch_has_no_write, aclk, aresetn, (m_tvalid && m_reg.branch_taken) |-> ((m_reg.status == mie_pkg::ST_OK) && !m_reg.reg_write && !m_reg.mem_write), "taken branch reports a write or fault")

endmodule

`default_nettype wire

// File: tb/sv/mips_itype_execute_unit_tb.sv
// ----------------------------------------------------------------------------
// MIPS I-format execute unit testbench
// Streams instruction words into the execute unit and checks every result
// transaction against a cycle-free model of the register file, data memory
// and PC. A directed opening covers each opcode and the trap, misalignment,
// r0, address wrap and PC wrap cases; bursts of random instructions follow,
// with random sender gaps and a rotating receiver stall pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mips_itype_execute_unit_tb;

    localparam int MEM_WORDS    = 1024;
    localparam int IDX_W        = $clog2(MEM_WORDS);
    localparam int RANDOM_ITEMS = 1200;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 20;

    // Result layout, last field first so next_pc lands in the low bits
    typedef struct packed {
        logic [1:0]  pad;
        logic [1:0]  status;
        logic        branch_taken;
        logic [31:0] mem_data;
        logic [3:0]  mem_byte_mask;
        logic [31:0] mem_address;
        logic        mem_write;
        logic [31:0] reg_value;
        logic [4:0]  reg_index;
        logic        reg_write;
        logic [31:0] next_pc;
    } exec_result_t;

    // Architectural state tracker and the queue of results it predicts
    class exec_scoreboard;
        logic [31:0]  gpr [32];
        logic [31:0]  dmem [MEM_WORDS];
        logic [31:0]  pc;
        exec_result_t pending [$];
        int           errors;

        function new();
            foreach (gpr[i]) gpr[i] = '0;
            foreach (dmem[i]) dmem[i] = '0;
            pc = '0;
            errors = 0;
        endfunction

        // Execute one accepted instruction and queue its result
        function void note_instr(logic [31:0] w);
            logic [5:0]       op;
            logic [4:0]       rs, rt;
            logic [15:0]      imm;
            logic [31:0]      simm, a, b, ea, pc4, sum;
            logic             rw;
            logic [IDX_W-1:0] idx;
            exec_result_t     r;

            op   = w[31:26];
            rs   = w[25:21];
            rt   = w[20:16];
            imm  = w[15:0];
            simm = {{16{imm[15]}}, imm};
            a    = gpr[rs];
            b    = gpr[rt];
            ea   = a + simm;
            pc4  = pc + 32'd4;
            idx  = IDX_W'((ea >> 2) % MEM_WORDS);
            rw   = 1'b0;
            r    = '0;
            r.next_pc = pc4;
            r.status  = mie_pkg::ST_OK;

            case (op)
                mie_pkg::OP_ADDI: begin
                    sum = a + simm;
                    if (a[31] == simm[31] && sum[31] != a[31]) begin
                        r.status = mie_pkg::ST_OVERFLOW;
                    end else begin
                        rw = 1'b1;
                        r.reg_value = sum;
                    end
                end
                mie_pkg::OP_ADDIU: begin
                    rw = 1'b1;
                    r.reg_value = a + simm;
                end
                mie_pkg::OP_ANDI: begin
                    rw = 1'b1;
                    r.reg_value = a & {16'h0, imm};
                end
                mie_pkg::OP_ORI: begin
                    rw = 1'b1;
                    r.reg_value = a | {16'h0, imm};
                end
                mie_pkg::OP_SLTI: begin
                    rw = 1'b1;
                    r.reg_value = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
                end
                mie_pkg::OP_LUI: begin
                    rw = 1'b1;
                    r.reg_value = {imm, 16'h0};
                end
                mie_pkg::OP_BEQ, mie_pkg::OP_BNE: begin
                    r.branch_taken = (op == mie_pkg::OP_BEQ) ? (a == b) : (a != b);
                    if (r.branch_taken) r.next_pc = pc4 + (simm << 2);
                end
                mie_pkg::OP_LW: begin
                    r.mem_address = ea;
                    if (ea[1:0] != 2'b00) begin
                        r.status = mie_pkg::ST_MISALIGN;
                    end else begin
                        rw = 1'b1;
                        r.reg_value = dmem[idx];
                    end
                end
                mie_pkg::OP_SW: begin
                    r.mem_address = ea;
                    if (ea[1:0] != 2'b00) begin
                        r.status = mie_pkg::ST_MISALIGN;
                    end else begin
                        r.mem_write     = 1'b1;
                        r.mem_byte_mask = 4'b1111;
                        r.mem_data      = b;
                    end
                end
                mie_pkg::OP_SH: begin
                    r.mem_address = ea;
                    if (ea[0]) begin
                        r.status = mie_pkg::ST_MISALIGN;
                    end else begin
                        r.mem_write     = 1'b1;
                        r.mem_byte_mask = ea[1] ? 4'b1100 : 4'b0011;
                        r.mem_data      = ea[1] ? {b[15:0], 16'h0} : {16'h0, b[15:0]};
                    end
                end
                mie_pkg::OP_SB: begin
                    r.mem_address   = ea;
                    r.mem_write     = 1'b1;
                    r.mem_byte_mask = 4'b0001 << ea[1:0];
                    r.mem_data      = {24'h0, b[7:0]} << {ea[1:0], 3'b000};
                end
                default: begin
                    r.status = mie_pkg::ST_UNKNOWN;
                end
            endcase

            // Writes to r0 are dropped and reported as no write
            if (rw && rt != 5'd0) begin
                r.reg_write = 1'b1;
                r.reg_index = rt;
                gpr[rt] = r.reg_value;
            end else begin
                r.reg_value = '0;
            end

            // Merge store data into its byte lanes
            if (r.mem_write) begin
                for (int i = 0; i < 4; i++) begin
                    if (r.mem_byte_mask[i]) dmem[idx][8*i +: 8] = r.mem_data[8*i +: 8];
                end
            end

            pc = r.next_pc;
            pending.insert(pending.size(), r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
            end
        endfunction

        // Compare one result transaction with the oldest prediction
        function void check_result(exec_result_t got);
            exec_result_t want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t ns: result expected none actual %h", $time, got);
                return;
            end
            want = pending.pop_front();
            compare_field("next_pc", want.next_pc, got.next_pc);
            compare_field("reg_write", 32'(want.reg_write), 32'(got.reg_write));
            compare_field("reg_index", 32'(want.reg_index), 32'(got.reg_index));
            compare_field("reg_value", want.reg_value, got.reg_value);
            compare_field("mem_write", 32'(want.mem_write), 32'(got.mem_write));
            compare_field("mem_address", want.mem_address, got.mem_address);
            compare_field("mem_byte_mask", 32'(want.mem_byte_mask),
                          32'(got.mem_byte_mask));
            compare_field("mem_data", want.mem_data, got.mem_data);
            compare_field("branch_taken", 32'(want.branch_taken), 32'(got.branch_taken));
            compare_field("status", 32'(want.status), 32'(got.status));
        endfunction
    endclass

    logic                        aclk     = 1'b0;
    logic                        aresetn  = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [mie_pkg::INSTR_W-1:0] s_tdata  = '0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [mie_pkg::RES_W-1:0]   m_tdata;

    exec_scoreboard sb;
    int unsigned    cycle_count = 0;
    int unsigned    rx_tick     = 0;

    mips_itype_execute_unit #(
        .MEM_WORDS(MEM_WORDS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #2 aclk = ~aclk;

    function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // Mostly well-formed instructions, biased toward a small memory window
    // and a few hot registers so loads see stores and hazards occur
    function automatic logic [31:0] random_instr();
        logic [5:0] ops [12] = '{mie_pkg::OP_ADDI, mie_pkg::OP_ADDIU, mie_pkg::OP_ANDI,
                                 mie_pkg::OP_ORI, mie_pkg::OP_SLTI, mie_pkg::OP_LUI,
                                 mie_pkg::OP_BEQ, mie_pkg::OP_BNE, mie_pkg::OP_LW,
                                 mie_pkg::OP_SW, mie_pkg::OP_SH, mie_pkg::OP_SB};
        logic [5:0]  op;
        logic [4:0]  rs, rt;
        logic [15:0] imm;
        if ($urandom_range(0, 99) < 8) return $urandom();
        op  = ops[4'($urandom_range(0, 11))];
        rs  = $urandom_range(0, 1) ? 5'($urandom_range(0, 7)) : 5'($urandom_range(0, 31));
        rt  = $urandom_range(0, 1) ? 5'($urandom_range(0, 7)) : 5'($urandom_range(0, 31));
        imm = 16'($urandom());
        case (op)
            mie_pkg::OP_LW, mie_pkg::OP_SW, mie_pkg::OP_SH, mie_pkg::OP_SB: begin
                if ($urandom_range(0, 1)) rs = 5'd0;
                if ($urandom_range(0, 9) != 0) begin
                    imm = 16'($urandom_range(0, 63) << 2);
                    if (op == mie_pkg::OP_SB || op == mie_pkg::OP_SH ||
                        $urandom_range(0, 7) == 0)
                        imm[1:0] = 2'($urandom_range(0, 3));
                end
            end
            mie_pkg::OP_BEQ, mie_pkg::OP_BNE: begin
                if ($urandom_range(0, 3) == 0) rt = rs;
            end
            default: ;
        endcase
        return itype(op, rs, rt, imm);
    endfunction

    // Offer one instruction and hold it until accepted
    task automatic send_instr(input logic [31:0] w);
        s_tdata  <= w;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_instr(w);
        @(negedge aclk);
    endtask

    // Receiver stall pattern, rotating through four modes
    always @(negedge aclk) begin
        rx_tick <= rx_tick + 1;
        case ((rx_tick / 150) % 4)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 5) == 0);
            default: m_tready <= (rx_tick % 3 != 0);
        endcase
    end

    // Check each result transaction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready)
            sb.check_result(m_tdata);
    end

    // Timeout guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("mips_itype_execute_unit: mismatch");
            $finish;
        end
    end

    initial begin
        int burst_left;
        int gap;

        sb = new();
        burst_left = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed opening: every opcode, immediate extremes, traps, wraps
        send_instr(itype(mie_pkg::OP_LUI,   5'd0, 5'd1, 16'h8000));  // r1 = most negative
        send_instr(itype(mie_pkg::OP_ADDI,  5'd1, 5'd2, 16'hffff));  // negative overflow
        send_instr(itype(mie_pkg::OP_ORI,   5'd0, 5'd3, 16'hffff));  // zero-extended
        send_instr(itype(mie_pkg::OP_LUI,   5'd0, 5'd4, 16'h7fff));
        send_instr(itype(mie_pkg::OP_ORI,   5'd4, 5'd4, 16'hffff));  // r4 = most positive
        send_instr(itype(mie_pkg::OP_ADDI,  5'd4, 5'd5, 16'h0001));  // positive overflow
        send_instr(itype(mie_pkg::OP_ADDIU, 5'd4, 5'd5, 16'h0001));  // wraps silently
        send_instr(itype(mie_pkg::OP_ADDIU, 5'd0, 5'd6, 16'hffff));  // r6 = all ones
        send_instr(itype(mie_pkg::OP_ANDI,  5'd6, 5'd7, 16'h8001));
        send_instr(itype(mie_pkg::OP_SLTI,  5'd1, 5'd8, 16'h0000));
        send_instr(itype(mie_pkg::OP_SLTI,  5'd4, 5'd9, 16'h8000));
        send_instr(itype(mie_pkg::OP_ADDI,  5'd6, 5'd0, 16'h0005));  // r0 destination
        send_instr(itype(mie_pkg::OP_SW,    5'd0, 5'd6, 16'h0000));
        send_instr(itype(mie_pkg::OP_SB,    5'd0, 5'd4, 16'h0001));
        send_instr(itype(mie_pkg::OP_SH,    5'd0, 5'd3, 16'h0002));
        send_instr(itype(mie_pkg::OP_LW,    5'd0, 5'd10, 16'h0000)); // merged lanes
        send_instr(itype(mie_pkg::OP_LW,    5'd0, 5'd11, 16'h0001)); // misaligned
        send_instr(itype(mie_pkg::OP_SW,    5'd0, 5'd6, 16'h0002));  // misaligned
        send_instr(itype(mie_pkg::OP_SH,    5'd0, 5'd6, 16'h0003));  // misaligned
        send_instr(itype(mie_pkg::OP_SW,    5'd5, 5'd4, 16'h0000));  // far address, word 0
        send_instr(itype(mie_pkg::OP_LW,    5'd0, 5'd12, 16'h1000)); // index wraps to 0
        send_instr(itype(mie_pkg::OP_LW,    5'd0, 5'd13, 16'hfffc)); // last word
        send_instr(32'hffff_ffff);                                   // unknown opcode
        send_instr(32'h0000_0000);                                   // register format
        send_instr(itype(mie_pkg::OP_BEQ,   5'd0, 5'd0, 16'h8000));  // backward, PC wraps
        send_instr(itype(mie_pkg::OP_BNE,   5'd1, 5'd0, 16'h7fff));  // taken forward
        send_instr(itype(mie_pkg::OP_BEQ,   5'd1, 5'd0, 16'h0010));  // not taken
        send_instr(itype(mie_pkg::OP_BNE,   5'd0, 5'd0, 16'h0010));  // not taken

        // Random bursts with random gaps
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 9) < 3) ? 0 : int'($urandom_range(1, 6));
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
                burst_left = int'($urandom_range(1, 16));
            end
            send_instr(random_instr());
            burst_left--;
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results, then allow for stray ones
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0) begin
            $display("mips_itype_execute_unit: match");
        end else begin
            $display("mips_itype_execute_unit: mismatch");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/mie_pkg.sv
rtl/core/mie_regfile.sv
rtl/core/mie_data_mem.sv
rtl/core/mips_itype_execute_unit.sv
tb/sv/mips_itype_execute_unit_tb.sv
